### rtl/pts_pkg.sv
// pts_pkg: shared types, register indexes and codes for the polled threshold switch
// no dependencies; imported by every module under rtl
package pts_pkg;

  localparam int PERIOD_BITS_DEFAULT = 16;
  localparam int TEMP_BITS = 12;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [TEMP_BITS-1:0] THRESHOLD_RESET = TEMP_BITS'(200);
  localparam int HEATUP_RESET = 15;
  localparam int COOLDOWN_RESET = 60;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLE = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HEATUP = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COOLDOWN = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIGGER = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INVERT = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ARM_REQ = 3'd6;

  localparam logic [1:0] ZONE_UNKNOWN = 2'd0;
  localparam logic [1:0] ZONE_LOW = 2'd1;
  localparam logic [1:0] ZONE_HIGH = 2'd2;

  localparam logic [1:0] TRIG_LEVEL = 2'd0;
  localparam logic [1:0] TRIG_RISING = 2'd1;
  localparam logic [1:0] TRIG_FALLING = 2'd2;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_ARM = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic [TEMP_BITS-1:0] temperature;
    logic                 arm_value;
  } item_t;

  typedef struct packed {
    logic       switch_on;
    logic       switch_written;
    logic       is_armed;
    logic [1:0] zone;
  } result_t;

  typedef struct packed {
    logic                 enable;
    logic [TEMP_BITS-1:0] threshold;
    logic [1:0]           trigger_mode;
    logic                 invert_output;
    logic                 arm_required;
    logic                 arm_load;
  } ctrl_t;

endpackage

### rtl/pts_cfg.sv
// pts_cfg: configuration register file, written through the cfg channel
// depends on pts_pkg
module pts_cfg #(
  parameter int PERIOD_BITS = pts_pkg::PERIOD_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr,
  input  logic [pts_pkg::CFG_INDEX_BITS-1:0]  index,
  input  logic [pts_pkg::CFG_DATA_BITS-1:0]   data,
  output pts_pkg::ctrl_t                      ctrl,
  output logic [PERIOD_BITS-1:0]              heatup_period,
  output logic [PERIOD_BITS-1:0]              cooldown_period
);
  import pts_pkg::*;

  logic                 enable;
  logic [TEMP_BITS-1:0] threshold;
  logic [1:0]           trigger_mode;
  logic                 invert_output;
  logic                 arm_required;
  logic                 arm_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable          <= 1'b0;
      threshold       <= THRESHOLD_RESET;
      heatup_period   <= PERIOD_BITS'(HEATUP_RESET);
      cooldown_period <= PERIOD_BITS'(COOLDOWN_RESET);
      trigger_mode    <= TRIG_LEVEL;
      invert_output   <= 1'b0;
      arm_required    <= 1'b0;
      arm_load        <= 1'b0;
    end else begin
      arm_load <= 1'b0;
      if (wr) begin
        unique case (index)
          CFG_ENABLE:    enable          <= data[0];
          CFG_THRESHOLD: threshold       <= data[TEMP_BITS-1:0];
          CFG_HEATUP:    heatup_period   <= data[PERIOD_BITS-1:0];
          CFG_COOLDOWN:  cooldown_period <= data[PERIOD_BITS-1:0];
          CFG_TRIGGER:   trigger_mode    <= data[1:0];
          CFG_INVERT:    invert_output   <= data[0];
          CFG_ARM_REQ: begin
            arm_required <= data[0];
            arm_load     <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  assign ctrl = '{enable: enable, threshold: threshold, trigger_mode: trigger_mode,
                  invert_output: invert_output, arm_required: arm_required,
                  arm_load: arm_load};

endmodule

### rtl/pts_step.sv
// pts_step: poll counter, zone and switch state, and the per-item update logic
// depends on pts_pkg; control from pts_cfg
module pts_step #(
  parameter int PERIOD_BITS = pts_pkg::PERIOD_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  pts_pkg::item_t         item,
  input  pts_pkg::ctrl_t         ctrl,
  input  logic [PERIOD_BITS-1:0] heatup_period,
  input  logic [PERIOD_BITS-1:0] cooldown_period,
  output pts_pkg::result_t       result
);
  import pts_pkg::*;

  localparam logic [PERIOD_BITS-1:0] COUNT_MAX = '1;

  logic [PERIOD_BITS-1:0] poll_count, poll_count_next;
  logic [PERIOD_BITS-1:0] poll_period, poll_period_next;
  logic [1:0]             zone_state, zone_state_next;
  logic                   armed_flag, armed_flag_next;
  logic                   switch_level, switch_level_next;
  logic                   wrote;

  logic [PERIOD_BITS-1:0] count_inc;
  logic [1:0]             zone_new;
  logic                   edge_mode;
  logic                   drive;
  logic                   want;

  always_comb begin
    count_inc = (poll_count != COUNT_MAX) ? poll_count + 1'b1 : poll_count;
    zone_new  = (item.temperature >= ctrl.threshold) ? ZONE_HIGH : ZONE_LOW;
    edge_mode = (ctrl.trigger_mode == TRIG_RISING) || (ctrl.trigger_mode == TRIG_FALLING);
    unique case (ctrl.trigger_mode)
      TRIG_RISING: begin
        drive = (zone_state == ZONE_LOW) && (zone_new == ZONE_HIGH);
        want  = 1'b1;
      end
      TRIG_FALLING: begin
        drive = (zone_state == ZONE_HIGH) && (zone_new == ZONE_LOW);
        want  = 1'b0;
      end
      default: begin
        drive = 1'b1;
        want  = (zone_new == ZONE_HIGH);
      end
    endcase
  end

  always_comb begin
    poll_count_next   = poll_count;
    poll_period_next  = poll_period;
    zone_state_next   = zone_state;
    armed_flag_next   = armed_flag;
    switch_level_next = switch_level;
    wrote             = 1'b0;
    if (fire) begin
      if (item.mode == MODE_ARM) begin
        if (ctrl.arm_required) begin
          armed_flag_next = item.arm_value;
        end
      end else if (ctrl.enable) begin
        poll_count_next = count_inc;
        if (count_inc >= poll_period) begin
          poll_count_next = '0;
          if (zone_new != zone_state) begin
            if (drive && armed_flag) begin
              if (ctrl.arm_required && edge_mode) begin
                armed_flag_next = 1'b0;
              end
              if (switch_level != (want ^ ctrl.invert_output)) begin
                switch_level_next = want ^ ctrl.invert_output;
                wrote             = 1'b1;
              end
            end
            poll_period_next = (zone_new == ZONE_HIGH) ? cooldown_period : heatup_period;
            zone_state_next  = zone_new;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_count   <= PERIOD_BITS'(HEATUP_RESET);
      poll_period  <= PERIOD_BITS'(HEATUP_RESET);
      zone_state   <= ZONE_UNKNOWN;
      armed_flag   <= 1'b1;
      switch_level <= 1'b0;
    end else begin
      poll_count   <= poll_count_next;
      poll_period  <= poll_period_next;
      zone_state   <= zone_state_next;
      switch_level <= switch_level_next;
      armed_flag   <= ctrl.arm_load ? !ctrl.arm_required : armed_flag_next;
    end
  end

  assign result = '{switch_on: switch_level_next, switch_written: wrote,
                    is_armed: armed_flag_next, zone: zone_state_next};

endmodule

### rtl/pts_obuf.sv
// pts_obuf: two-entry result buffer between the update logic and the result channel
// depends on pts_pkg
module pts_obuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pts_pkg::result_t din,
  output logic             space,
  output logic             valid,
  input  logic             pop,
  output pts_pkg::result_t dout
);
  import pts_pkg::*;

  result_t    d0, d1;
  logic [1:0] count, count_next;

  assign space = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign dout  = d0;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd1) begin
        d0 <= din;
      end else begin
        d0 <= d1;
        d1 <= din;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        d0 <= din;
      end else begin
        d1 <= din;
      end
    end else if (pop) begin
      d0 <= d1;
    end
  end

endmodule

### rtl/polled_threshold_switch_core.sv
// polled_threshold_switch_core: top level of the polled threshold switch
// depends on pts_pkg, pts_cfg, pts_step, pts_obuf
//
// usage:
//   item channel (item_valid/item_ready/item): one tick or arm command per transfer
//   result channel (result_valid/result_ready/result): one result per item, in order
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes, always ready; the user must
//     issue them only while no item is in flight, unenforced by the block; indexes past the last register are dropped
// timing:
//   an item is captured in the input register, updated against the switch state when the
//   result buffer has space and lands in a two-entry result buffer, which offers the result
//   on the result channel; throughput is one item per cycle while the buffer has space,
//   set by the combinational state update loop
// stalls:
//   while result_ready is low the buffer absorbs two results and the input register one
//   more item; item_ready drops only when all three are occupied
// reset:
//   rst clears registers to their reset values, zone unknown, switch off, armed, and the
//   poll counter loaded so the first enabled tick polls
module polled_threshold_switch_core #(
  parameter int PERIOD_BITS = pts_pkg::PERIOD_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  pts_pkg::item_t                     item,
  output logic                               result_valid,
  input  logic                               result_ready,
  output pts_pkg::result_t                   result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pts_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [pts_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import pts_pkg::*;

  ctrl_t                  ctrl;
  logic [PERIOD_BITS-1:0] heatup_period;
  logic [PERIOD_BITS-1:0] cooldown_period;
  logic                   s1_valid;
  item_t                  s1_item;
  logic                   ob_space;
  logic                   step_fire;
  result_t                step_result;

  assign cfg_ready  = 1'b1;
  assign step_fire  = s1_valid && ob_space;
  assign item_ready = !s1_valid || ob_space;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_item <= item;
    end
  end

  pts_cfg #(.PERIOD_BITS(PERIOD_BITS)) u_cfg (
    .clk             (clk),
    .rst             (rst),
    .wr              (cfg_valid && cfg_ready),
    .index           (cfg_index),
    .data            (cfg_data),
    .ctrl            (ctrl),
    .heatup_period   (heatup_period),
    .cooldown_period (cooldown_period)
  );

  pts_step #(.PERIOD_BITS(PERIOD_BITS)) u_step (
    .clk             (clk),
    .rst             (rst),
    .fire            (step_fire),
    .item            (s1_item),
    .ctrl            (ctrl),
    .heatup_period   (heatup_period),
    .cooldown_period (cooldown_period),
    .result          (step_result)
  );

  pts_obuf u_obuf (
    .clk   (clk),
    .rst   (rst),
    .push  (step_fire),
    .din   (step_result),
    .space (ob_space),
    .valid (result_valid),
    .pop   (result_valid && result_ready),
    .dout  (result)
  );

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("item channel stalled with empty result buffer");

  a_arm_no_write: assert property (@(posedge clk) disable iff (rst)
    step_fire && s1_item.mode == MODE_ARM |-> !step_result.switch_written)
    else $error("arm command wrote the switch");

  a_disabled_no_write: assert property (@(posedge clk) disable iff (rst)
    step_fire && !ctrl.enable |-> !step_result.switch_written)
    else $error("switch written while disabled");

  a_written_flips: assert property (@(posedge clk) disable iff (rst)
    step_fire && ctrl.enable && s1_item.mode == MODE_TICK && step_result.switch_written
    |=> step_fire |-> step_result.switch_on == $past(step_result.switch_on)
        || step_result.switch_written)
    else $error("switch level changed without a write");

  a_zone_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.zone != 2'd3)
    else $error("illegal zone code on result");
`endif

endmodule
